@@ rtl/core/lz77d_pkg.sv @@
// Package for the LZ77 tag stream decompressor.
// Types, phase codes and status codes shared by the top level and the checker.
package lz77d_pkg;

  localparam int unsigned WinBytes = 65536;
  localparam int unsigned WinAw = $clog2(WinBytes);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TAG     = 3'd1,
    PH_LITLEN  = 3'd2,
    PH_LITERAL = 3'd3,
    PH_OFFSET  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_OFF = 2'd1,
    ST_PAST    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CP_IDLE = 2'd0,
    CP_READ = 2'd1,
    CP_EMIT = 2'd2
  } copy_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
    status_e    st;
    logic       done;
  } result_t;

endpackage

@@ rtl/core/lz77_tag_stream_decompressor.sv @@
// Top level of the LZ77 tag stream decompressor: parser, copy sequencer, output register.
// Depends on lz77d_pkg and lz77d_ram (history window).
//
// Usage: compressed bytes enter on in_byte_i/stream_start_i with in_valid_i; a beat is taken
// when in_valid_i is high and in_stall_o is low. stream_start_i clears the parse state before
// its byte is parsed. Results leave on out_*_o with out_valid_o; the receiver holds
// out_stall_i high to stall.
// Results: header, tag, length and offset bytes give no result, except that a bad offset gives
// one status result. A literal byte gives one result. A valid copy reads the window, then emits,
// for each output byte, and input is stalled until the copy ends.
// The single read port of the history RAM sets the copy rate.
// Output: each result is formed combinationally and held in the output register from the next cycle.
// A copy reading a byte written just before sees it because each read follows the write
// of the previous byte.
// Stall: while the output register is full and stalled, input is stalled and the copy waits.
// Reset: parse state clears; the window content stays undefined but is never read unwritten.
module lz77_tag_stream_decompressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       run_last_o,
  output logic [1:0] status_o,
  output logic       stream_complete_o
);
  localparam int unsigned Aw = lz77d_pkg::WinAw;

  lz77d_pkg::phase_e      phase_q, phase_d;
  lz77d_pkg::copy_state_e cst_q, cst_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [31:0] dlen_q, dlen_d;
  logic [31:0] pcnt_q, pcnt_d;
  logic [2:0]  xleft_q, xleft_d;
  logic [31:0] acc_q, acc_d;
  logic [32:0] lrem_q, lrem_d;
  logic [6:0]  clen_q, clen_d;
  logic [1:0]  ckind_q, ckind_d;
  logic [Aw-1:0] wp_q, wp_d;
  logic [Aw-1:0] off_q, off_d;

  logic ov_q, ov_d;
  lz77d_pkg::result_t res_q, res_d;

  logic          we;
  logic [7:0]    wdata;
  logic [Aw-1:0] raddr;
  logic [7:0]    rdata;

  lz77d_ram #(.Width(8), .Depth(lz77d_pkg::WinBytes)) u_win (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wp_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic out_free;
  assign out_free = !ov_q || !out_stall_i;
  assign in_stall_o = !out_free || (cst_q != lz77d_pkg::CP_IDLE);

  logic [31:0] off_full;
  logic [31:0] acc_n;
  logic [5:0]  upper;

  always_comb begin
    logic [31:0] dl;
    phase_d = phase_q; cst_d = cst_q; hidx_d = hidx_q; dlen_d = dlen_q; pcnt_d = pcnt_q;
    xleft_d = xleft_q; acc_d = acc_q; lrem_d = lrem_q; clen_d = clen_q; ckind_d = ckind_q;
    wp_d = wp_q; off_d = off_q;
    ov_d = ov_q && out_stall_i;
    res_d = res_q;
    we = 1'b0; wdata = in_byte_i;
    raddr = wp_q - off_q;
    upper = in_byte_i[7:2];
    acc_n = acc_q;
    off_full = '0;
    dl = dlen_q;
    unique case (cst_q)
      lz77d_pkg::CP_READ: begin
        cst_d = lz77d_pkg::CP_EMIT;
      end
      lz77d_pkg::CP_EMIT: begin
        if (out_free) begin
          we = 1'b1; wdata = rdata;
          wp_d = wp_q + Aw'(1);
          pcnt_d = (pcnt_q == 32'hFFFF_FFFF) ? pcnt_q : pcnt_q + 32'd1;
          clen_d = clen_q - 7'd1;
          ov_d = 1'b1;
          res_d.data = rdata; res_d.has = 1'b1; res_d.last = (clen_q == 7'd1);
          res_d.st = (pcnt_q >= dlen_q) ? lz77d_pkg::ST_PAST : lz77d_pkg::ST_OK;
          res_d.done = (pcnt_d == dlen_q);
          cst_d = (clen_q == 7'd1) ? lz77d_pkg::CP_IDLE : lz77d_pkg::CP_READ;
        end
      end
      default: begin
        if (in_valid_i && out_free) begin
          if (stream_start_i) begin
            phase_d = lz77d_pkg::PH_HEADER; hidx_d = '0; dl = '0; xleft_d = '0;
            acc_n = '0; lrem_d = '0; clen_d = '0; ckind_d = '0; wp_d = '0;
            dlen_d = '0; pcnt_d = '0; acc_d = '0;
          end
          unique case (stream_start_i ? lz77d_pkg::PH_HEADER : phase_q)
            lz77d_pkg::PH_HEADER: begin
              logic [2:0] hi;
              hi = stream_start_i ? 3'd0 : hidx_q;
              dlen_d = dl | (32'(in_byte_i[6:0]) << (7 * hi));
              hidx_d = hi + 3'd1;
              if (!in_byte_i[7] || hi >= 3'd4) begin
                hidx_d = '0; phase_d = lz77d_pkg::PH_TAG;
              end else phase_d = lz77d_pkg::PH_HEADER;
            end
            lz77d_pkg::PH_TAG: begin
              ckind_d = in_byte_i[1:0]; acc_d = '0; hidx_d = '0;
              if (in_byte_i[1:0] == 2'd0) begin
                if (upper < 6'd60) begin
                  lrem_d = 33'(upper) + 33'd1; phase_d = lz77d_pkg::PH_LITERAL;
                end else begin
                  xleft_d = 3'(upper - 6'd59); phase_d = lz77d_pkg::PH_LITLEN;
                end
              end else if (in_byte_i[1:0] == 2'd1) begin
                clen_d = 7'd4 + 7'(upper[2:0]);
                acc_d = 32'(in_byte_i[7:5]) << 8;
                xleft_d = 3'd1; phase_d = lz77d_pkg::PH_OFFSET;
              end else begin
                clen_d = 7'd1 + 7'(upper);
                xleft_d = (in_byte_i[1:0] == 2'd2) ? 3'd2 : 3'd4;
                phase_d = lz77d_pkg::PH_OFFSET;
              end
            end
            lz77d_pkg::PH_LITLEN: begin
              acc_n = acc_q | (32'(in_byte_i) << (8 * hidx_q[1:0]));
              acc_d = acc_n; hidx_d = hidx_q + 3'd1; xleft_d = xleft_q - 3'd1;
              if (xleft_q == 3'd1) begin
                lrem_d = 33'(acc_n) + 33'd1; hidx_d = '0; phase_d = lz77d_pkg::PH_LITERAL;
              end
            end
            lz77d_pkg::PH_LITERAL: begin
              we = 1'b1; wp_d = wp_q + Aw'(1);
              pcnt_d = (pcnt_q == 32'hFFFF_FFFF) ? pcnt_q : pcnt_q + 32'd1;
              ov_d = 1'b1;
              res_d.data = in_byte_i; res_d.has = 1'b1; res_d.last = 1'b1;
              res_d.st = (pcnt_q >= dlen_q) ? lz77d_pkg::ST_PAST : lz77d_pkg::ST_OK;
              res_d.done = (pcnt_d == dlen_q);
              lrem_d = lrem_q - 33'd1;
              if (lrem_q == 33'd1) phase_d = lz77d_pkg::PH_TAG;
            end
            lz77d_pkg::PH_OFFSET: begin
              if (ckind_q == 2'd1) acc_n = acc_q | 32'(in_byte_i);
              else acc_n = acc_q | (32'(in_byte_i) << (8 * hidx_q[1:0]));
              acc_d = acc_n; hidx_d = hidx_q + 3'd1; xleft_d = xleft_q - 3'd1;
              if (xleft_q == 3'd1) begin
                off_full = acc_n; hidx_d = '0; phase_d = lz77d_pkg::PH_TAG;
                if (off_full == 32'd0 || off_full > pcnt_q
                    || off_full > 32'(lz77d_pkg::WinBytes)) begin
                  ov_d = 1'b1;
                  res_d.data = '0; res_d.has = 1'b0; res_d.last = 1'b1;
                  res_d.st = lz77d_pkg::ST_BAD_OFF; res_d.done = (pcnt_q == dlen_q);
                end else begin
                  off_d = off_full[Aw-1:0];
                  cst_d = lz77d_pkg::CP_READ;
                end
              end
            end
            default: phase_d = lz77d_pkg::PH_TAG;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lz77d_pkg::PH_HEADER; cst_q <= lz77d_pkg::CP_IDLE;
      hidx_q <= '0; dlen_q <= '0; pcnt_q <= '0; xleft_q <= '0; acc_q <= '0;
      lrem_q <= '0; clen_q <= '0; ckind_q <= '0; wp_q <= '0; off_q <= '0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; cst_q <= cst_d; hidx_q <= hidx_d; dlen_q <= dlen_d;
      pcnt_q <= pcnt_d; xleft_q <= xleft_d; acc_q <= acc_d; lrem_q <= lrem_d;
      clen_q <= clen_d; ckind_q <= ckind_d; wp_q <= wp_d; off_q <= off_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o = res_q.data;
  assign has_byte_o = res_q.has;
  assign run_last_o = res_q.last;
  assign status_o = res_q.st;
  assign stream_complete_o = res_q.done;
endmodule

@@ rtl/core/lz77d_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data. No dependencies.
module lz77d_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/core/lz77d_checker.sv @@
// Port-level checker for the LZ77 tag stream decompressor, bound to the top level.
// Depends on the top-level ports and lz77d_pkg.
module lz77d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic [1:0] status_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result changed");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= lz77d_pkg::ST_PAST)
    else $error("bad status code");
  a_badoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == lz77d_pkg::ST_BAD_OFF |-> !has_byte_o && out_byte_o == 8'd0)
    else $error("bad offset result carries data");
endmodule

bind lz77_tag_stream_decompressor lz77d_checker u_lz77d_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_byte_o (out_byte_o),
  .has_byte_o (has_byte_o),
  .status_o   (status_o)
);
